/* sv/longest_common_substring_length_core_assert.svh */
// assertion macros for the longest common substring length core
`ifndef LONGEST_COMMON_SUBSTRING_LENGTH_CORE_ASSERT_SVH
`define LONGEST_COMMON_SUBSTRING_LENGTH_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define LCSL_ASSERT_SAME(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);
`define LCSL_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);
`else
`define LCSL_ASSERT_SAME(name, pre, post, msg)
`define LCSL_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

/* sv/lcsl_pkg.sv */
package lcsl_pkg;

   localparam int MAX_LEN = 128;
   localparam int RUN_W   = $clog2(MAX_LEN + 1);
   localparam int SYM_W   = 8;
   localparam int BEST_W  = 8;

   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_FIRST  = 2'd1,
      ACT_SECOND = 2'd2,
      ACT_REPORT = 2'd3
   } action_type;

   typedef struct packed {
      logic             clear;
      logic             append;
      logic             second;
      logic [SYM_W-1:0] symbol;
   } cell_ctrl_type;

   typedef struct packed {
      logic             valid;
      logic [RUN_W-1:0] run;
      logic [RUN_W-1:0] best;
   } cell_link_type;

   function automatic logic [BEST_W-1:0] sat_best(input logic [RUN_W-1:0] value);
      logic [BEST_W-1:0] result;
      if (32'(value) > 32'd255) begin
         result = 8'hff;
      end else begin
         result = BEST_W'(value);
      end
      return result;
   endfunction

endpackage

/* sv/lcsl_cell.sv */
module lcsl_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  lcsl_pkg::cell_ctrl_type ctrl,
   input  lcsl_pkg::cell_link_type left,
   output lcsl_pkg::cell_link_type right
);

   logic                         valid_ff;
   logic                         valid_in;
   logic [lcsl_pkg::SYM_W-1:0]   symbol_ff;
   logic [lcsl_pkg::SYM_W-1:0]   symbol_in;
   logic [lcsl_pkg::RUN_W-1:0]   run_ff;
   logic [lcsl_pkg::RUN_W-1:0]   run_in;
   logic [lcsl_pkg::RUN_W-1:0]   best_ff;
   logic [lcsl_pkg::RUN_W-1:0]   best_in;
   logic [lcsl_pkg::RUN_W-1:0]   carry_max;

   always_comb begin
      valid_in  = valid_ff;
      symbol_in = symbol_ff;
      run_in    = run_ff;
      // running maximum ripples one cell per cycle
      carry_max = (left.best > best_ff) ? left.best : best_ff;
      best_in   = (run_ff > carry_max) ? run_ff : carry_max;
      if (ctrl.clear) begin
         valid_in = 1'b0;
         run_in   = '0;
         best_in  = '0;
      end else if (ctrl.append && !valid_ff && left.valid) begin
         valid_in  = 1'b1;
         symbol_in = ctrl.symbol;
         run_in    = '0;
      end else if (ctrl.second) begin
         if (valid_ff && (symbol_ff == ctrl.symbol)) begin
            run_in = left.run + lcsl_pkg::RUN_W'(1);
         end else begin
            run_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         run_ff   <= '0;
         best_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         run_ff   <= run_in;
         best_ff  <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      symbol_ff <= symbol_in;
   end

   assign right.valid = valid_ff;
   assign right.run   = run_ff;
   assign right.best  = best_ff;

endmodule

/* sv/longest_common_substring_length_core.sv */
// Longest common substring length. Each request carries an action and a symbol: clear starts
// a new pair, first-string appends fill a row of MAX_LEN (128) cells left to right, and each
// second-string symbol updates every cell's diagonal run in parallel. Clear, append and
// second-string requests are taken one per cycle. A report request waits until the running
// maximum has rippled through the whole cell row (no wait if no second-string symbol came
// since the last clear or since a full sweep), and also waits while an earlier response is
// stalled; its response appears in the cycle after it is taken. Appends beyond capacity or
// after the second string has started are dropped and raise the overflow flag until the
// next clear.
`include "longest_common_substring_length_core_assert.svh"

module longest_common_substring_length_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_action,
   input  logic [lcsl_pkg::SYM_W-1:0]    req_symbol,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lcsl_pkg::BEST_W-1:0]   rsp_best_length,
   output logic                          rsp_overflow
);

   lcsl_pkg::action_type          action;
   logic                          req_take;
   logic                          settled;
   lcsl_pkg::cell_ctrl_type       ctrl;
   lcsl_pkg::cell_link_type       link [0:lcsl_pkg::MAX_LEN];
   logic [lcsl_pkg::MAX_LEN-1:0]  valid_row;

   logic                          second_started_ff;
   logic                          second_started_in;
   logic                          overflow_seen_ff;
   logic                          overflow_seen_in;
   logic [lcsl_pkg::RUN_W-1:0]    settle_ff;
   logic [lcsl_pkg::RUN_W-1:0]    settle_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [lcsl_pkg::BEST_W-1:0]   rsp_best_ff;
   logic [lcsl_pkg::BEST_W-1:0]   rsp_best_in;
   logic                          rsp_overflow_ff;
   logic                          rsp_overflow_in;

   assign action   = lcsl_pkg::action_type'(req_action);
   assign settled  = (settle_ff == lcsl_pkg::RUN_W'(lcsl_pkg::MAX_LEN));
   assign req_stall = (action == lcsl_pkg::ACT_REPORT) &&
                      (!settled || (rsp_valid_ff && rsp_stall));
   assign req_take = req_valid && !req_stall;

   assign ctrl.clear  = req_take && (action == lcsl_pkg::ACT_CLEAR);
   assign ctrl.append = req_take && (action == lcsl_pkg::ACT_FIRST) && !second_started_ff;
   assign ctrl.second = req_take && (action == lcsl_pkg::ACT_SECOND);
   assign ctrl.symbol = req_symbol;

   assign link[0].valid = 1'b1;
   assign link[0].run   = '0;
   assign link[0].best  = '0;

   for (genvar i = 0; i < lcsl_pkg::MAX_LEN; i++) begin : g_cell
      lcsl_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctrl  (ctrl),
         .left  (link[i]),
         .right (link[i+1])
      );
      assign valid_row[i] = link[i+1].valid;
   end

   always_comb begin
      second_started_in = second_started_ff;
      overflow_seen_in  = overflow_seen_ff;
      settle_in         = settled ? settle_ff : settle_ff + lcsl_pkg::RUN_W'(1);
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_best_in       = rsp_best_ff;
      rsp_overflow_in   = rsp_overflow_ff;
      if (req_take) begin
         case (action)
            lcsl_pkg::ACT_CLEAR: begin
               second_started_in = 1'b0;
               overflow_seen_in  = 1'b0;
               settle_in         = lcsl_pkg::RUN_W'(lcsl_pkg::MAX_LEN);
            end
            lcsl_pkg::ACT_FIRST: begin
               if (second_started_ff || link[lcsl_pkg::MAX_LEN].valid) begin
                  overflow_seen_in = 1'b1;
               end
            end
            lcsl_pkg::ACT_SECOND: begin
               second_started_in = 1'b1;
               settle_in         = '0;
            end
            lcsl_pkg::ACT_REPORT: begin
               rsp_valid_in    = 1'b1;
               rsp_best_in     = lcsl_pkg::sat_best(link[lcsl_pkg::MAX_LEN].best);
               rsp_overflow_in = overflow_seen_ff;
            end
            default: begin
               rsp_valid_in = rsp_valid_ff && rsp_stall;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_started_ff <= 1'b0;
         overflow_seen_ff  <= 1'b0;
         settle_ff         <= lcsl_pkg::RUN_W'(lcsl_pkg::MAX_LEN);
         rsp_valid_ff      <= 1'b0;
      end else begin
         second_started_ff <= second_started_in;
         overflow_seen_ff  <= overflow_seen_in;
         settle_ff         <= settle_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_best_ff     <= rsp_best_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_best_length = rsp_best_ff;
   assign rsp_overflow    = rsp_overflow_ff;

   `LCSL_ASSERT_NEXT(a_report_gives_response,
      req_take && (action == lcsl_pkg::ACT_REPORT), rsp_valid,
      "report request did not produce a response")
   `LCSL_ASSERT_SAME(a_report_only_when_settled,
      req_take && (action == lcsl_pkg::ACT_REPORT), settled,
      "report taken before the running maximum settled")
   `LCSL_ASSERT_SAME(a_best_within_first_length,
      1'b1, 32'(link[lcsl_pkg::MAX_LEN].best) <= 32'($countones(valid_row)),
      "best run exceeds stored first string length")
   `LCSL_ASSERT_NEXT(a_overflow_sticky,
      overflow_seen_ff && !ctrl.clear, overflow_seen_ff,
      "overflow flag dropped without a clear")

endmodule
